// ----- hw/rtl/c2sb_pkg.sv -----
package c2sb_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_DRAIN = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_ROWS  = 2'd0,
        REG_COLS  = 2'd1,
        REG_KROWS = 2'd2,
        REG_KCOLS = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ROW_M,
        ST_ROW_Q,
        ST_ROW_S,
        ST_TAP,
        ST_FLUSH
    } t_state;

    localparam int ROW_W = 16;
    localparam int REG_W = 16;

endpackage

// ----- hw/rtl/conv2d_symmetric_border.sv -----
// Channel  | Direction | Word contents (lowest bits first)
// s_axis   | in        | tdata: coeff_index, sample; tuser: operation
// m_axis   | out       | tdata: out_value, out_row, out_col; tlast: out_last
// cfg      | in        | write enable, register index, data
//
// A coefficient load is stored and an ignored code dropped. A pixel or drain word
// triggers a due check; if an output is due, each kernel row runs the row-slot steps
// (ROW_M, ROW_Q, ROW_S), then its taps through the single line-store read port at one
// kernel tap a cycle, and FLUSH waits for a free output. Synchronous active-low reset
// clears control state and sets the default configuration, but not the stores.
// A stalled output holds its word while the next input word is taken.
module conv2d_symmetric_border #(
    parameter int MAX_COLS        = 1024,
    parameter int MAX_KERNEL      = 7,
    parameter int PIXEL_BITS      = 16,
    parameter int COEFF_FRAC_BITS = 14,
    localparam int COEFF_BITS = COEFF_FRAC_BITS + 2,
    localparam int SW         = (PIXEL_BITS > COEFF_BITS) ? PIXEL_BITS : COEFF_BITS,
    localparam int CI_W       = $clog2(MAX_KERNEL * MAX_KERNEL + 1),
    localparam int CW         = $clog2(MAX_COLS),
    localparam int VALUE_BITS = PIXEL_BITS + COEFF_FRAC_BITS + 7,
    localparam int IN_DW      = ((CI_W + SW + 7) / 8) * 8,
    localparam int OUT_DW     = ((VALUE_BITS + 16 + CW + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DW-1:0]      i_s_axis_tdata,   // coeff_index, sample
    input  logic [1:0]            i_s_axis_tuser,   // operation
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DW-1:0]     o_m_axis_tdata,   // out_value, out_row, out_col
    output logic                  o_m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_addr,
    input  logic [c2sb_pkg::REG_W-1:0] i_cfg_data
);
    import c2sb_pkg::*;

    localparam int KW     = $clog2(MAX_KERNEL + 1);
    localparam int SLW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int ADDR_W = $clog2(MAX_KERNEL * MAX_COLS);
    localparam int CDEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int CA_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int SH     = ROW_W + $clog2(MAX_KERNEL) + 1;
    localparam longint RECIP = ((64'd1 << SH) + MAX_KERNEL - 1) / MAX_KERNEL;
    localparam int RCP_W  = SH + 1;
    localparam int PROD_W = PIXEL_BITS + COEFF_BITS;
    localparam int NW     = 15;

    function automatic logic [16:0] f_mirror(input logic signed [18:0] k,
                                             input logic [16:0] n);
        logic signed [18:0] t;
        logic signed [18:0] nn;
        begin
            nn = signed'({2'b00, n});
            t  = k;
            if (t < 0) begin
                t = -t - 19'sd1;
            end else if (t >= nn) begin
                t = 19'sd2 * nn - t - 19'sd1;
            end
            if (t < 0) begin
                t = '0;
            end
            if (t > nn - 19'sd1) begin
                t = nn - 19'sd1;
            end
            return t[16:0];
        end
    endfunction

    // configuration
    logic [15:0] r_rows;
    logic [10:0] r_cols;
    logic [2:0]  r_krows, r_kcols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= 16'd1024;
            r_cols  <= 11'd1024;
            r_krows <= 3'd3;
            r_kcols <= 3'd3;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_addr))
                REG_ROWS:  r_rows  <= i_cfg_data[15:0];
                REG_COLS:  r_cols  <= i_cfg_data[10:0];
                REG_KROWS: r_krows <= i_cfg_data[2:0];
                REG_KCOLS: r_kcols <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    logic [16:0]   nr, nc;
    logic [KW-1:0] kr, kc;
    logic [NW-1:0] cols_w;

    always_comb begin
        cols_w = NW'(r_cols);
        nr = (r_rows == '0) ? 17'd1 : {1'b0, r_rows};
        if (r_cols == '0) begin
            nc = 17'd1;
        end else if (cols_w > NW'(MAX_COLS)) begin
            nc = 17'(MAX_COLS);
        end else begin
            nc = 17'(r_cols);
        end
        kr = (4'(r_krows) > 4'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(r_krows);
        kc = (4'(r_kcols) > 4'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(r_kcols);
    end

    // input word fields
    logic [CI_W-1:0] in_idx;
    logic [SW-1:0]   in_sample;
    t_op             in_op;
    logic            in_acc;

    assign in_idx    = i_s_axis_tdata[CI_W-1:0];
    assign in_sample = i_s_axis_tdata[CI_W +: SW];
    assign in_op     = t_op'(i_s_axis_tuser);

    // counters
    t_state r_state, n_state;
    logic [ROW_W-1:0] r_in_row, r_emit_row;
    logic [CW-1:0]    r_in_col, r_emit_col;
    logic [SLW-1:0]   r_in_slot;
    logic [KW-1:0]    r_mi, r_mj;
    logic [ROW_W-1:0] r_m;
    logic [ROW_W+RCP_W-1:0] r_mprod;
    logic [SLW-1:0]   r_slot;

    logic             r_v1, r_v2;
    logic signed [PIXEL_BITS-1:0] r_px;
    logic signed [COEFF_BITS-1:0] r_cf;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [VALUE_BITS-1:0] r_acc;

    logic r_ov;
    logic signed [VALUE_BITS-1:0] r_o_value;
    logic [ROW_W-1:0] r_o_row;
    logic [CW-1:0]    r_o_col;
    logic             r_o_last;

    // due check
    logic [16:0] rr, cc, rr_s, cc_s;
    logic        due, last, kzero;

    always_comb begin
        rr_s = {1'b0, r_emit_row} + 17'(kr >> 1);
        rr   = (rr_s > nr - 17'd1) ? nr - 17'd1 : rr_s;
        cc_s = 17'(r_emit_col) + 17'(kc >> 1);
        cc   = (cc_s > nc - 17'd1) ? nc - 17'd1 : cc_s;
        due  = (17'(r_in_row) > rr) || ((17'(r_in_row) == rr) && (17'(r_in_col) > cc));
        last = ({1'b0, r_emit_row} + 17'd1 >= nr) && (17'(r_emit_col) + 17'd1 >= nc);
        kzero = (kr == '0) || (kc == '0);
    end

    // tap addressing
    logic [16:0] row_m, col_n;
    logic [ROW_W-1:0] q;
    logic [ROW_W+4:0] rem;
    logic tap_last_col, tap_last_row, pipe_empty, out_free;

    always_comb begin
        row_m = f_mirror(signed'({3'b000, r_emit_row}) + signed'(19'(kr >> 1))
                         - signed'(19'(r_mi)), nr);
        col_n = f_mirror(signed'(19'(r_emit_col)) + signed'(19'(kc >> 1))
                         - signed'(19'(r_mj)), nc);
        q   = r_mprod[SH +: ROW_W];
        rem = (ROW_W+5)'(r_m) - (ROW_W+5)'(q * MAX_KERNEL);
        if (rem >= (ROW_W+5)'(MAX_KERNEL)) begin
            rem = rem - (ROW_W+5)'(MAX_KERNEL);
        end
        tap_last_col = (r_mj == kc - KW'(1));
        tap_last_row = (r_mi == kr - KW'(1));
        pipe_empty   = !r_v1 && !r_v2;
        out_free     = !r_ov || i_m_axis_tready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (in_op == OP_PIXEL || in_op == OP_DRAIN)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!due) begin
                    n_state = ST_IDLE;
                end else if (kzero) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_ROW_M;
                end
            end
            ST_ROW_M: n_state = ST_ROW_Q;
            ST_ROW_Q: n_state = ST_ROW_S;
            ST_ROW_S: n_state = ST_TAP;
            ST_TAP: begin
                if (tap_last_col) begin
                    n_state = tap_last_row ? ST_FLUSH : ST_ROW_M;
                end
            end
            ST_FLUSH: begin
                if (pipe_empty && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic do_emit, do_issue;

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        do_issue        = (r_state == ST_TAP);
        do_emit         = (r_state == ST_FLUSH) && pipe_empty && out_free;
    end

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // stores
    logic signed [PIXEL_BITS-1:0] line_mem [MAX_KERNEL*MAX_COLS];
    logic signed [COEFF_BITS-1:0] coeff_mem [CDEPTH];
    logic [CW-1:0]     wr_col;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CA_W-1:0]   cf_rd_addr;
    logic              pix_wr;

    always_comb begin
        wr_col     = r_in_col;
        wr_addr    = ADDR_W'(32'(r_in_slot) * MAX_COLS + 32'(wr_col));
        rd_addr    = ADDR_W'(32'(r_slot) * MAX_COLS + 32'(col_n));
        cf_rd_addr = CA_W'(32'(r_mi) * MAX_KERNEL + 32'(r_mj));
        pix_wr     = in_acc && (in_op == OP_PIXEL) && (17'(r_in_row) < nr);
    end

    always_ff @(posedge i_clk) begin
        if (pix_wr) begin
            line_mem[wr_addr] <= in_sample[PIXEL_BITS-1:0];
        end
        if (in_acc && in_op == OP_LOAD && 32'(in_idx) < CDEPTH) begin
            coeff_mem[CA_W'(in_idx)] <= in_sample[COEFF_BITS-1:0];
        end
        r_px   <= line_mem[rd_addr];
        r_cf   <= coeff_mem[cf_rd_addr];
        r_prod <= PROD_W'(r_px * r_cf);
        r_m     <= row_m[ROW_W-1:0];
        r_mprod <= (ROW_W+RCP_W)'(r_m * RCP_W'(RECIP));
        if (r_state == ST_ROW_S) begin
            r_slot <= rem[SLW-1:0];
        end
        if (do_emit) begin
            r_o_value <= r_acc;
            r_o_row   <= r_emit_row;
            r_o_col   <= r_emit_col;
            r_o_last  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_emit_row <= '0;
            r_emit_col <= '0;
            r_mi       <= '0;
            r_mj       <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_acc      <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= do_issue;
            r_v2    <= r_v1;
            if (r_v2) begin
                r_acc <= r_acc + VALUE_BITS'(r_prod);
            end
            if (pix_wr) begin
                if (17'(r_in_col) + 17'd1 >= nc) begin
                    r_in_col  <= '0;
                    r_in_row  <= r_in_row + 1'b1;
                    r_in_slot <= (32'(r_in_slot) == MAX_KERNEL - 1) ? '0 : r_in_slot + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
            if (r_state == ST_CHECK) begin
                r_acc <= '0;
                r_mi  <= '0;
                r_mj  <= '0;
            end
            if (do_issue) begin
                if (tap_last_col) begin
                    r_mj <= '0;
                    r_mi <= r_mi + 1'b1;
                end else begin
                    r_mj <= r_mj + 1'b1;
                end
            end
            if (do_emit) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (do_emit) begin
                if (last) begin
                    r_in_row   <= '0;
                    r_in_col   <= '0;
                    r_in_slot  <= '0;
                    r_emit_row <= '0;
                    r_emit_col <= '0;
                end else if (17'(r_emit_col) + 17'd1 >= nc) begin
                    r_emit_col <= '0;
                    r_emit_row <= r_emit_row + 1'b1;
                end else begin
                    r_emit_col <= r_emit_col + 1'b1;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = OUT_DW'({r_o_col, r_o_row, r_o_value});

endmodule

// ----- tb/tb_conv2d_symmetric_border.sv -----
module tb_conv2d_symmetric_border;
    import c2sb_pkg::*;

    localparam int LINE_W   = 1024;
    localparam int KMAX     = 7;
    localparam int SETTLE   = 120;
    localparam int WDOG_MAX = 20000;
    localparam int HOLD_LEN = 400;

    typedef struct packed {
        logic [36:0] value;
        logic [15:0] row;
        logic [9:0]  col;
        logic        last;
    } conv_word_t;

    typedef struct {
        t_op         op;
        logic [5:0]  idx;
        logic [15:0] smp;
        int          tx_idle;
        int          rx_idle;
        bit          hold;
    } in_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [23:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_data;
    logic        m_last;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;

    conv2d_symmetric_border dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow of the block: stores, position counters and registers.
    logic signed [15:0] line_mem [KMAX*LINE_W];
    logic signed [15:0] coef_mem [KMAX*KMAX];
    int unsigned in_row, in_col, emit_row, emit_col;
    int unsigned img_rows, img_cols, ker_rows, ker_cols;

    in_word_t   pending_words[$];
    conv_word_t expected_conv[$];
    int         words_queued, convs_expected, frames_done;
    int         errors, mismatches;
    int         rx_idle_pct;
    bit         hold_req;
    int         hold_cnt;
    int         quiet_cycles;

    function automatic int mirror(int k, int n);
        if (k < 0) k = -k - 1;
        else if (k >= n) k = 2 * n - k - 1;
        if (k < 0) k = 0;
        if (k > n - 1) k = n - 1;
        return k;
    endfunction

    function automatic longint conv_sum(int i, int j, int nr, int nc);
        longint acc;
        int m, n;
        acc = 0;
        for (int mi = 0; mi < ker_rows; mi++) begin
            m = mirror(i + ker_rows / 2 - mi, nr);
            for (int mj = 0; mj < ker_cols; mj++) begin
                n = mirror(j + ker_cols / 2 - mj, nc);
                acc += longint'(coef_mem[mi*KMAX+mj]) * longint'(line_mem[(m % KMAX)*LINE_W+n]);
            end
        end
        return acc;
    endfunction

    // Advances the shadow by one word; returns 1 when an output position is due.
    function automatic bit conv_step(in_word_t w, output conv_word_t res);
        int unsigned nr, nc, rr, cc;
        longint acc;
        nr = (img_rows == 0) ? 1 : img_rows;
        nc = (img_cols == 0) ? 1 : ((img_cols > LINE_W) ? LINE_W : img_cols);
        res = '0;
        if (w.op == OP_LOAD) begin
            if (w.idx < KMAX * KMAX) coef_mem[w.idx] = w.smp;
            return 0;
        end
        if (w.op == OP_NONE) return 0;
        if (w.op == OP_PIXEL && in_row < nr) begin
            line_mem[(in_row % KMAX)*LINE_W + in_col] = w.smp;
            in_col++;
            if (in_col >= nc) begin
                in_col = 0;
                in_row++;
            end
        end
        rr = emit_row + ker_rows / 2;
        if (rr > nr - 1) rr = nr - 1;
        cc = emit_col + ker_cols / 2;
        if (cc > nc - 1) cc = nc - 1;
        if (!(in_row > rr || (in_row == rr && in_col > cc))) return 0;
        acc = conv_sum(emit_row, emit_col, nr, nc);
        res.value = acc[36:0];
        res.row = emit_row[15:0];
        res.col = emit_col[9:0];
        res.last = (emit_row + 1 >= nr) && (emit_col + 1 >= nc);
        if (res.last) begin
            in_row = 0; in_col = 0; emit_row = 0; emit_col = 0;
        end else begin
            emit_col++;
            if (emit_col >= nc) begin
                emit_col = 0;
                emit_row = (emit_row + 1) & 16'hFFFF;
            end
        end
        return 1;
    endfunction

    int mode_tx, mode_rx;

    // Queues one word and its prediction; returns 1 if it closed the frame.
    function automatic bit send_word(t_op op, logic [5:0] idx, logic [15:0] smp, bit hold = 0);
        in_word_t w;
        conv_word_t r;
        w.op = op; w.idx = idx; w.smp = smp;
        w.tx_idle = mode_tx; w.rx_idle = mode_rx; w.hold = hold;
        pending_words.push_back(w);
        words_queued++;
        if (conv_step(w, r)) begin
            expected_conv.push_back(r);
            convs_expected++;
            if (r.last) frames_done++;
            return r.last;
        end
        return 0;
    endfunction

    task automatic wait_idle();
        while (pending_words.size() != 0 || expected_conv.size() != 0 || s_valid)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg r, int unsigned v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= r;
        cfg_data <= v[15:0];
        case (r)
            REG_ROWS:  img_rows = v & 16'hFFFF;
            REG_COLS:  img_cols = v & 11'h7FF;
            REG_KROWS: ker_rows = v & 3'h7;
            default:   ker_cols = v & 3'h7;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_shape(int unsigned r, int unsigned c, int unsigned kr, int unsigned kc);
        wait_idle();
        write_reg(REG_ROWS, r);
        write_reg(REG_COLS, c);
        write_reg(REG_KROWS, kr);
        write_reg(REG_KCOLS, kc);
    endtask

    // One frame of random or extreme pixels, optionally with stray words mixed in, then drain ticks.
    task automatic run_frame(bit noisy, bit edge_pix, int hold_at = -1);
        int npix;
        bit done;
        logic [15:0] px;
        done = 0;
        npix = img_rows * img_cols;
        for (int p = 0; p < npix && !done; p++) begin
            if (noisy && $urandom_range(99) < 10) begin
                case ($urandom_range(2))
                    0: done = send_word(OP_NONE, 6'($urandom), 16'($urandom));
                    1: done = send_word(OP_LOAD, 6'($urandom), 16'($urandom));
                    default: done = send_word(OP_DRAIN, 6'($urandom), 16'($urandom));
                endcase
            end
            px = 16'($urandom);
            if (edge_pix) px = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            if (!done) done = send_word(OP_PIXEL, 6'($urandom), px, p == hold_at);
        end
        // A pixel beyond the full frame is dropped by the block.
        if (!done && noisy && $urandom_range(2) == 0)
            done = send_word(OP_PIXEL, 6'($urandom), 16'($urandom));
        while (!done) done = send_word(OP_DRAIN, 6'($urandom), 16'($urandom));
    endtask

    initial begin
        mode_tx = 28; mode_rx = 87;
        img_rows = 1024; img_cols = 1024; ker_rows = 3; ker_cols = 3;
        in_row = 0; in_col = 0; emit_row = 0; emit_col = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme coefficients, every opcode, kernel larger than the image.
        for (int k = 0; k < KMAX * KMAX; k++)
            void'(send_word(OP_LOAD, 6'(k), (k % 2) ? 16'h7FFF : 16'h8000));
        void'(send_word(OP_LOAD, 6'd63, 16'h5555));
        void'(send_word(OP_NONE, 6'd0, 16'hFFFF));
        set_shape(2, 2, 7, 7);
        run_frame(0, 1);
        set_shape(3, 5, 1, 7);
        run_frame(1, 1);
        set_shape(4, 3, 7, 1);
        run_frame(1, 0);

        for (int k = 0; k < KMAX * KMAX; k++)
            void'(send_word(OP_LOAD, 6'(k), 16'($urandom)));

        while (words_queued < 1150) begin
            if (words_queued > 420) begin
                mode_tx = 87; mode_rx = 28;
            end
            if (words_queued > 800) begin
                mode_tx = 0; mode_rx = 0;
            end
            set_shape($urandom_range(2, 9), $urandom_range(2, 14),
                      $urandom_range(1, 7), $urandom_range(1, 7));
            run_frame(1, 0, (words_queued > 800 && words_queued < 900) ? 3 : -1);
        end

        // Size extremes: a wide line and a tall narrow image.
        set_shape(2, 256, 3, 5);
        run_frame(1, 0);
        set_shape(100, 2, 1, 3);
        run_frame(1, 0);
        set_shape(65535, 2, 1, 1);
        wait_idle();
        set_shape(2, 2, 1, 1);
        run_frame(0, 0);

        wait_idle();
        $display("Covered %0d words over %0d frames, %0d output positions checked,",
                 words_queued, frames_done, convs_expected);
        $display("image sizes 2x2 to 2x256 and 100x2, kernels 1x1 to 7x7, all opcodes.");
        if (errors == 0 && mismatches == 0)
            $display("conv2d_symmetric_border regression: pass");
        else
            $display("conv2d_symmetric_border regression: fail");
        $finish;
    end

    // Driver: a new word is presented only once the current one has been taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            hold_req <= 1'b0;
        end else begin
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 &&
                    $urandom_range(99) >= pending_words[0].tx_idle) begin
                    s_valid <= 1'b1;
                    s_data <= {2'b00, pending_words[0].smp, pending_words[0].idx};
                    s_user <= pending_words[0].op;
                    rx_idle_pct <= pending_words[0].rx_idle;
                    hold_req <= pending_words[0].hold;
                    void'(pending_words.pop_front());
                end else begin
                    s_valid <= 1'b0;
                    hold_req <= 1'b0;
                end
            end else begin
                hold_req <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus long hold-offs requested by marked words.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            hold_cnt <= 0;
        end else if (hold_req) begin
            hold_cnt <= HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: compares each accepted output word with the oldest prediction.
    always @(posedge i_clk) begin
        conv_word_t want;
        conv_word_t got;
        if (i_rst_n && m_valid && m_ready) begin
            got.value = m_data[36:0];
            got.row = m_data[52:37];
            got.col = m_data[62:53];
            got.last = m_last;
            if (expected_conv.size() == 0) begin
                errors++;
                if (errors + mismatches <= 10)
                    $display("unexpected output word: value %0d row %0d col %0d last %0b",
                             $signed(got.value), got.row, got.col, got.last);
            end else begin
                want = expected_conv.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (errors + mismatches <= 10)
                        $display({"mismatch: exp value %0d row %0d col %0d last %0b, ",
                                  "got value %0d row %0d col %0d last %0b"},
                                 $signed(want.value), want.row, want.col, want.last,
                                 $signed(got.value), got.row, got.col, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("watchdog expired with %0d outputs outstanding", expected_conv.size());
            $display("conv2d_symmetric_border regression: fail");
            $finish;
        end
    end

endmodule
